@@ design/led_alert_blink_sequencer_defines.svh @@
// Assertion macros shared by the sequencer RTL.
`ifndef LED_ALERT_BLINK_SEQUENCER_DEFINES_SVH
`define LED_ALERT_BLINK_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
`define LABS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("labs assertion failed");
`define LABS_NEVER(lbl, clk, rst, expr) `LABS_ASSERT(lbl, clk, rst, !(expr))
`else
`define LABS_ASSERT(lbl, clk, rst, prop)
`define LABS_NEVER(lbl, clk, rst, expr)
`endif
`endif

@@ design/labs_pkg.sv @@
package labs_pkg;

   localparam int MAX_PATTERNS = 4;
   localparam int WORD_W       = 43;
   localparam int MS_W         = 12;
   localparam int REP_W        = 16;
   localparam int LEVEL_W      = 8;
   localparam int CODE_W       = 2;
   localparam int CSR_INDEX_W  = 3;
   localparam int QUEUE_DEPTH  = 2;

   // pattern word layout
   localparam int ON_LSB  = 3;
   localparam int OFF_LSB = 15;
   localparam int REP_LSB = 27;

   localparam logic CMD_TICK    = 1'b0;
   localparam logic CMD_REQUEST = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_BRIGHTNESS = 3'd4;
   localparam logic [LEVEL_W-1:0]     BRIGHTNESS_RESET = 8'd10;

   typedef logic [WORD_W-1:0] labs_word_type;
   typedef labs_word_type [MAX_PATTERNS-1:0] labs_words_type;

   localparam labs_words_type PAT_RESET = {
      43'd166993730,
      43'd134234116003,
      43'd274990657,
      43'd134217728
   };

   typedef struct packed {
      logic                    tick;
      logic [MAX_PATTERNS-1:0] mask;
   } labs_cmd_type;

   typedef struct packed {
      logic         valid;
      labs_cmd_type cmd;
   } labs_queue_type;

   typedef struct packed {
      logic              found;
      logic [CODE_W-1:0] idx;
   } labs_pick_type;

   function automatic logic [MS_W-1:0] pat_on(input labs_word_type w);
      return w[ON_LSB +: MS_W];
   endfunction

   function automatic logic [MS_W-1:0] pat_off(input labs_word_type w);
      return w[OFF_LSB +: MS_W];
   endfunction

   function automatic logic [REP_W-1:0] pat_rep(input labs_word_type w);
      return w[REP_LSB +: REP_W];
   endfunction

   function automatic logic playable(input labs_word_type w);
      return (pat_rep(w) != '0) && ((pat_on(w) != '0) || (pat_off(w) != '0));
   endfunction

endpackage

@@ design/labs_front.sv @@
`include "led_alert_blink_sequencer_defines.svh"

module labs_front import labs_pkg::*; #(
   parameter int NumPatterns = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_cmd,
   input  logic [CODE_W-1:0] req_alert_code,
   output labs_queue_type    q_out,
   input  logic              q_take
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   labs_cmd_type     ent_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   labs_cmd_type     cls;
   logic             enq, deq;

   // classify: a request beyond the pattern count becomes an empty mask
   always_comb begin
      cls      = '0;
      cls.tick = (req_cmd == CMD_TICK);
      if (req_cmd == CMD_REQUEST && int'(req_alert_code) < NumPatterns) begin
         cls.mask[req_alert_code] = 1'b1;
      end
   end

   assign req_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign enq       = req_valid && req_ready;
   assign deq       = q_take && (count_ff != '0);

   assign q_out.valid = (count_ff != '0);
   assign q_out.cmd   = ent_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (enq) begin
         tail_in = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (deq) begin
         head_in = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (enq && !deq) begin
         count_in = count_ff + 1'b1;
      end else if (deq && !enq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         ent_ff[tail_ff] <= cls;
      end
   end

   `LABS_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(QUEUE_DEPTH))
   `LABS_ASSERT(a_count_grow, clock, reset, (enq && !deq) |=> count_ff == $past(count_ff) + 1'b1)

endmodule

@@ design/labs_back.sv @@
`include "led_alert_blink_sequencer_defines.svh"

module labs_back import labs_pkg::*; #(
   parameter int NumPatterns = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  labs_queue_type     q_in,
   output logic               q_take,
   input  labs_words_type     pat_words,
   input  logic [LEVEL_W-1:0] brightness,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [LEVEL_W-1:0] rsp_led_red,
   output logic [LEVEL_W-1:0] rsp_led_green,
   output logic [LEVEL_W-1:0] rsp_led_blue,
   output logic               rsp_busy_res,
   output logic [CODE_W-1:0]  rsp_active_pattern
);

   // lowest playable active pattern at or above first
   function automatic labs_pick_type pick(input logic [MAX_PATTERNS-1:0] act,
                                          input logic [CODE_W:0] first,
                                          input labs_words_type w);
      labs_pick_type p;
      p = '0;
      for (int i = MAX_PATTERNS - 1; i >= 0; i--) begin
         if (i < NumPatterns && (CODE_W+1)'(i) >= first && act[i] && playable(w[i])) begin
            p.found = 1'b1;
            p.idx   = CODE_W'(i);
         end
      end
      return p;
   endfunction

   logic [MAX_PATTERNS-1:0] pend_ff, pend_in, act_ff, act_in;
   logic [CODE_W-1:0]       idx_ff, idx_in;
   logic                    lit_ff, lit_in, run_ff, run_in;
   logic [MS_W-1:0]         ms_ff, ms_in, ms_dec;
   logic [REP_W-1:0]        rep_ff, rep_in, rep_dec;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]      red_ff, green_ff, blue_ff, lvl;
   logic                    busy_ff;
   logic [CODE_W-1:0]       apat_ff;
   labs_pick_type           pick_next, pick_first;
   labs_word_type           cur_word, nxt_word, fst_word, out_word;
   logic                    take;

   assign take   = q_in.valid && (!rsp_valid_ff || rsp_ready);
   assign q_take = take;

   assign pick_next  = pick(act_ff, {1'b0, idx_ff} + 1'b1, pat_words);
   assign pick_first = pick(pend_ff, '0, pat_words);
   assign cur_word   = pat_words[idx_ff];
   assign nxt_word   = pat_words[pick_next.idx];
   assign fst_word   = pat_words[pick_first.idx];
   assign rep_dec    = rep_ff - 1'b1;
   assign ms_dec     = (ms_ff != '0) ? ms_ff - 1'b1 : '0;

   always_comb begin
      pend_in = pend_ff;
      act_in  = act_ff;
      idx_in  = idx_ff;
      lit_in  = lit_ff;
      ms_in   = ms_ff;
      rep_in  = rep_ff;
      run_in  = run_ff;
      if (take) begin
         if (!q_in.cmd.tick) begin
            pend_in = pend_ff | q_in.cmd.mask;
         end else begin
            if (run_ff) begin
               ms_in = ms_dec;
               if (ms_dec == '0) begin
                  if (lit_ff && pat_off(cur_word) != '0) begin
                     lit_in = 1'b0;
                     ms_in  = pat_off(cur_word);
                  end else if (rep_dec != '0) begin
                     rep_in = rep_dec;
                     lit_in = (pat_on(cur_word) != '0);
                     ms_in  = (pat_on(cur_word) != '0) ? pat_on(cur_word) : pat_off(cur_word);
                  end else if (pick_next.found) begin
                     idx_in = pick_next.idx;
                     rep_in = pat_rep(nxt_word);
                     lit_in = (pat_on(nxt_word) != '0);
                     ms_in  = (pat_on(nxt_word) != '0) ? pat_on(nxt_word) : pat_off(nxt_word);
                  end else begin
                     run_in = 1'b0;
                     act_in = '0;
                     idx_in = '0;
                     lit_in = 1'b0;
                     ms_in  = '0;
                     rep_in = '0;
                  end
               end
            end
            // start a new pass from the pending set, on the same tick if one just ended
            if (!run_in && pend_ff != '0) begin
               pend_in = '0;
               if (pick_first.found) begin
                  run_in = 1'b1;
                  act_in = pend_ff;
                  idx_in = pick_first.idx;
                  rep_in = pat_rep(fst_word);
                  lit_in = (pat_on(fst_word) != '0);
                  ms_in  = (pat_on(fst_word) != '0) ? pat_on(fst_word) : pat_off(fst_word);
               end else begin
                  run_in = 1'b0;
                  act_in = '0;
                  idx_in = '0;
                  lit_in = 1'b0;
                  ms_in  = '0;
                  rep_in = '0;
               end
            end
         end
      end
   end

   assign out_word     = pat_words[idx_in];
   assign lvl          = (run_in && lit_in) ? brightness : '0;
   assign rsp_valid_in = take || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         act_ff       <= '0;
         idx_ff       <= '0;
         lit_ff       <= 1'b0;
         ms_ff        <= '0;
         rep_ff       <= '0;
         run_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         act_ff       <= act_in;
         idx_ff       <= idx_in;
         lit_ff       <= lit_in;
         ms_ff        <= ms_in;
         rep_ff       <= rep_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result word until taken
   always_ff @(posedge clock) begin
      if (take) begin
         red_ff   <= out_word[0] ? lvl : '0;
         green_ff <= out_word[1] ? lvl : '0;
         blue_ff  <= out_word[2] ? lvl : '0;
         busy_ff  <= run_in;
         apat_ff  <= run_in ? idx_in : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_led_red        = red_ff;
   assign rsp_led_green      = green_ff;
   assign rsp_led_blue       = blue_ff;
   assign rsp_busy_res       = busy_ff;
   assign rsp_active_pattern = apat_ff;

   `LABS_ASSERT(a_rsp_hold, clock, reset, (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(red_ff) && $stable(apat_ff)))
   `LABS_ASSERT(a_idle_clean, clock, reset, !run_ff |-> (act_ff == '0 && lit_ff == 1'b0))
   `LABS_NEVER(a_dark_when_idle, clock, reset, rsp_valid_ff && !busy_ff && (red_ff != '0 || green_ff != '0 || blue_ff != '0 || apat_ff != '0))

endmodule

@@ design/led_alert_blink_sequencer.sv @@
// LED alert blink sequencer.
// Request channel (req_*): each word is either a one-millisecond tick
// (req_cmd low) or a request that marks pattern req_alert_code pending.
// Result channel (rsp_*): exactly one word per request word, in order,
// giving the LED levels, busy flag and playing pattern after that word.
// Configuration (csr_*): pattern words 0..3 and brightness at index 4,
// written on any cycle with csr_we high; write only while idle.
// Path: an accepted word is written into the command queue, then taken by
// the sequencer update, which registers its result in the result register.
// Throughput: one word per cycle unless rsp_ready stalls; the sequencer
// update is combinational into the result register, and the two-entry
// command queue lets the front keep accepting while a result waits.
// Reset: pending and active sets clear, playback stops, queue and result
// register empty; pattern words and brightness return to their defaults.
// A stalled receiver holds the result word; the queue fills, then
// req_ready drops until results drain.
module led_alert_blink_sequencer import labs_pkg::*; #(
   parameter int NumPatterns = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_cmd,
   input  logic [CODE_W-1:0]      req_alert_code,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [LEVEL_W-1:0]     rsp_led_red,
   output logic [LEVEL_W-1:0]     rsp_led_green,
   output logic [LEVEL_W-1:0]     rsp_led_blue,
   output logic                   rsp_busy_res,
   output logic [CODE_W-1:0]      rsp_active_pattern,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_wdata
);

   labs_words_type     pat_view;
   logic [LEVEL_W-1:0] bright_ff;
   labs_queue_type     q_bus;
   logic               q_take;

   for (genvar i = 0; i < MAX_PATTERNS; i++) begin : g_pat
      if (i < NumPatterns) begin : g_used
         labs_word_type pat_ff;
         always_ff @(posedge clock) begin
            if (reset) begin
               pat_ff <= PAT_RESET[i];
            end else if (csr_we && csr_index == CSR_INDEX_W'(i)) begin
               pat_ff <= csr_wdata;
            end
         end
         assign pat_view[i] = pat_ff;
      end else begin : g_unused
         assign pat_view[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff <= BRIGHTNESS_RESET;
      end else if (csr_we && csr_index == REG_BRIGHTNESS) begin
         bright_ff <= csr_wdata[LEVEL_W-1:0];
      end
   end

   labs_front #(.NumPatterns(NumPatterns)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_alert_code (req_alert_code),
      .q_out          (q_bus),
      .q_take         (q_take)
   );

   labs_back #(.NumPatterns(NumPatterns)) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_in               (q_bus),
      .q_take             (q_take),
      .pat_words          (pat_view),
      .brightness         (bright_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_led_red        (rsp_led_red),
      .rsp_led_green      (rsp_led_green),
      .rsp_led_blue       (rsp_led_blue),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_active_pattern (rsp_active_pattern)
   );

endmodule
